// ===== rtl/core/slfs_pkg.sv =====
// Package: shared types, register indexes, action codes and reset values of the line follower.
`timescale 1ns / 1ps

package slfs_pkg;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_X        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEER_GAIN      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RESUME_SPEED    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STEER_LIMIT     = 3'd7;

    // Register reset values
    localparam logic [7:0] RST_WHITE_THRESHOLD = 8'd160;
    localparam logic [9:0] RST_MIN_RUN_WIDTH   = 10'd10;
    localparam logic [9:0] RST_STOP_COUNT      = 10'd106;
    localparam logic [7:0] RST_BASE_SPEED      = 8'd100;
    localparam logic [9:0] RST_TARGET_X        = 10'd30;
    localparam logic [7:0] RST_STEER_GAIN      = 8'd16;
    localparam logic [7:0] RST_RESUME_SPEED    = 8'd70;
    localparam logic [9:0] RST_STEER_LIMIT     = 10'd80;

    // Action codes
    localparam logic [1:0] ACT_STOP   = 2'd0;
    localparam logic [1:0] ACT_RESUME = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_STEER  = 2'd3;

    // Fixed search turn speeds
    localparam logic signed [11:0] SEARCH_RIGHT = 12'sd100;
    localparam logic signed [11:0] SEARCH_LEFT  = 12'sd20;

    // Saturation limits
    localparam logic [9:0]  COL_MAX   = 10'h3FF;
    localparam logic [10:0] COUNT_MAX = 11'h7FF;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } slfs_in_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [11:0] right_speed;
        logic signed [11:0] left_speed;
        logic [10:0]        white_count;
        logic [9:0]         edge_x;
        logic               last;
    } slfs_out_t;

    typedef struct packed {
        logic [7:0] white_threshold;
        logic [9:0] min_run_width;
        logic [9:0] stop_count;
        logic [7:0] base_speed;
        logic [9:0] target_x;
        logic [7:0] steer_gain;
        logic [7:0] resume_speed;
        logic [9:0] steer_limit;
    } slfs_cfg_t;

    // Row decision handed from the row tracker to the drive stage
    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] white_count;
        logic [9:0]  edge_x;
    } slfs_dec_t;

endpackage

// ===== rtl/core/slfs_cfg_regs.sv =====
// Configuration register bank of the line follower.
`timescale 1ns / 1ps

module slfs_cfg_regs
    import slfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output slfs_cfg_t              cfg
);

    slfs_cfg_t cfg_reg;
    slfs_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    // Decode the write, masking data to the register width
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WHITE_THRESHOLD: cfg_next.white_threshold = cfg_data[7:0];
                REG_MIN_RUN_WIDTH:   cfg_next.min_run_width   = cfg_data[9:0];
                REG_STOP_COUNT:      cfg_next.stop_count      = cfg_data[9:0];
                REG_BASE_SPEED:      cfg_next.base_speed      = cfg_data[7:0];
                REG_TARGET_X:        cfg_next.target_x        = cfg_data[9:0];
                REG_STEER_GAIN:      cfg_next.steer_gain      = cfg_data[7:0];
                REG_RESUME_SPEED:    cfg_next.resume_speed    = cfg_data[7:0];
                REG_STEER_LIMIT:     cfg_next.steer_limit     = cfg_data[9:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.white_threshold <= RST_WHITE_THRESHOLD;
            cfg_reg.min_run_width   <= RST_MIN_RUN_WIDTH;
            cfg_reg.stop_count      <= RST_STOP_COUNT;
            cfg_reg.base_speed      <= RST_BASE_SPEED;
            cfg_reg.target_x        <= RST_TARGET_X;
            cfg_reg.steer_gain      <= RST_STEER_GAIN;
            cfg_reg.resume_speed    <= RST_RESUME_SPEED;
            cfg_reg.steer_limit     <= RST_STEER_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/slfs_row_track.sv =====
// Row tracker: input register, per-pixel run and count update, row decision register.
`timescale 1ns / 1ps

module slfs_row_track
    import slfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  slfs_cfg_t cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  slfs_in_t  s_data,
    output logic      dec_valid,
    output slfs_dec_t dec,
    input  logic      dec_pop
);

    logic        in_valid_reg;
    logic        in_valid_next;
    slfs_in_t    in_reg;

    logic [9:0]  column_reg,     column_next;
    logic [10:0] run_length_reg, run_length_next;
    logic [10:0] white_total_reg, white_total_next;
    logic        line_found_reg, line_found_next;
    logic [9:0]  edge_reg,       edge_next;

    logic        dec_valid_reg,  dec_valid_next;
    slfs_dec_t   dec_reg,        dec_next;

    logic        white;
    logic        emit;
    logic        dec_free;
    logic        step;
    logic [10:0] min_run;

    assign min_run  = {1'b0, cfg.min_run_width};
    assign dec_free = !dec_valid_reg || dec_pop;
    // A row end needs room in the decision register; other pixels always pass
    assign step     = in_valid_reg && (!in_reg.row_end || dec_free);
    assign s_ready  = !in_valid_reg || step;

    assign dec_valid = dec_valid_reg;
    assign dec       = dec_reg;

    // Hold the input item until the tracker takes it
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // Advance the row state and form the row decision
    always_comb begin
        white            = in_reg.pixel > cfg.white_threshold;
        column_next      = column_reg;
        run_length_next  = run_length_reg;
        white_total_next = white_total_reg;
        line_found_next  = line_found_reg;
        edge_next        = edge_reg;
        emit             = 1'b0;
        dec_next         = dec_reg;

        if (white) begin
            if (white_total_reg != COUNT_MAX) begin
                white_total_next = white_total_reg + 11'd1;
            end
            if (run_length_reg != COUNT_MAX) begin
                run_length_next = run_length_reg + 11'd1;
            end
        end else begin
            // close the run that ended on the previous column
            if (run_length_reg > min_run && column_reg != 10'd0) begin
                edge_next       = column_reg - 10'd1;
                line_found_next = 1'b1;
            end
            run_length_next = 11'd0;
        end

        if (!in_reg.row_end) begin
            if (column_reg != COL_MAX) begin
                column_next = column_reg + 10'd1;
            end
        end else begin
            // a white final pixel closes its run at its own column
            if (white && run_length_next > min_run) begin
                edge_next       = column_reg;
                line_found_next = 1'b1;
            end

            dec_next.white_count = white_total_next;
            dec_next.edge_x      = line_found_next ? edge_next : 10'd0;
            if (white_total_next > {1'b0, cfg.stop_count}) begin
                dec_next.action = ACT_STOP;
                emit            = 1'b1;
            end else if (!line_found_next) begin
                dec_next.action = ACT_SEARCH;
                emit            = 1'b1;
            end else if (edge_next < cfg.steer_limit) begin
                dec_next.action = ACT_STEER;
                emit            = 1'b1;
            end

            // clear the row
            column_next      = 10'd0;
            run_length_next  = 11'd0;
            white_total_next = 11'd0;
            line_found_next  = 1'b0;
            edge_next        = 10'd0;
        end
    end

    // Load a decision at row end, drop it once the drive stage is done
    always_comb begin
        dec_valid_next = dec_valid_reg;
        if (step && in_reg.row_end && emit) begin
            dec_valid_next = 1'b1;
        end else if (dec_pop) begin
            dec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            dec_valid_reg   <= 1'b0;
            column_reg      <= 10'd0;
            run_length_reg  <= 11'd0;
            white_total_reg <= 11'd0;
            line_found_reg  <= 1'b0;
            edge_reg        <= 10'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            dec_valid_reg <= dec_valid_next;
            if (step) begin
                column_reg      <= column_next;
                run_length_reg  <= run_length_next;
                white_total_reg <= white_total_next;
                line_found_reg  <= line_found_next;
                edge_reg        <= edge_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (step && in_reg.row_end && emit) begin
            dec_reg <= dec_next;
        end
    end

endmodule

// ===== rtl/core/slfs_drive_out.sv =====
// Drive stage: motor speeds from the row decision, result register.
`timescale 1ns / 1ps

module slfs_drive_out
    import slfs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  slfs_cfg_t cfg,
    input  logic      dec_valid,
    input  slfs_dec_t dec,
    output logic      dec_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output slfs_out_t m_data
);

    logic               m_valid_reg, m_valid_next;
    slfs_out_t          out_reg,     out_next;
    logic               resume_reg,  resume_next;

    logic               out_load;
    logic               stop_first;
    logic signed [10:0] diff;
    logic signed [19:0] prod;
    logic signed [19:0] prod_adj;
    logic signed [15:0] term;
    logic signed [16:0] base_ext;
    logic signed [16:0] left_sum;
    logic signed [16:0] right_sum;
    logic signed [11:0] left_sat;
    logic signed [11:0] right_sat;

    assign out_load   = !m_valid_reg || m_ready;
    // a stop decision yields the stop item first, then the resume item
    assign stop_first = (dec.action == ACT_STOP) && !resume_reg;
    assign dec_pop    = dec_valid && out_load && !stop_first;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Proportional steering, term truncated toward zero
    always_comb begin
        diff      = $signed({1'b0, dec.edge_x}) - $signed({1'b0, cfg.target_x});
        prod      = diff * $signed({1'b0, cfg.steer_gain});
        prod_adj  = prod + (prod[19] ? 20'sd15 : 20'sd0);
        term      = prod_adj[19:4];
        base_ext  = $signed({9'd0, cfg.base_speed});
        left_sum  = base_ext + 17'(term);
        right_sum = base_ext - 17'(term);

        if (left_sum > 17'sd2047) begin
            left_sat = 12'sd2047;
        end else if (left_sum < -17'sd2048) begin
            left_sat = -12'sd2048;
        end else begin
            left_sat = left_sum[11:0];
        end

        if (right_sum > 17'sd2047) begin
            right_sat = 12'sd2047;
        end else if (right_sum < -17'sd2048) begin
            right_sat = -12'sd2048;
        end else begin
            right_sat = right_sum[11:0];
        end
    end

    // Build the next result item
    always_comb begin
        out_next             = out_reg;
        out_next.white_count = dec.white_count;
        out_next.edge_x      = dec.edge_x;
        out_next.last        = 1'b1;
        case (dec.action)
            ACT_STOP: begin
                if (resume_reg) begin
                    out_next.action      = ACT_RESUME;
                    out_next.right_speed = $signed({4'd0, cfg.resume_speed});
                    out_next.left_speed  = $signed({4'd0, cfg.resume_speed});
                end else begin
                    out_next.action      = ACT_STOP;
                    out_next.right_speed = 12'sd0;
                    out_next.left_speed  = 12'sd0;
                    out_next.last        = 1'b0;
                end
            end
            ACT_SEARCH: begin
                out_next.action      = ACT_SEARCH;
                out_next.right_speed = SEARCH_RIGHT;
                out_next.left_speed  = SEARCH_LEFT;
            end
            ACT_STEER: begin
                out_next.action      = ACT_STEER;
                out_next.right_speed = right_sat;
                out_next.left_speed  = left_sat;
            end
            default: begin
                out_next.action      = dec.action;
                out_next.right_speed = 12'sd0;
                out_next.left_speed  = 12'sd0;
            end
        endcase
    end

    // Advance the result register and the stop/resume phase
    always_comb begin
        m_valid_next = m_valid_reg;
        resume_next  = resume_reg;
        if (out_load) begin
            m_valid_next = dec_valid;
            if (dec_valid) begin
                resume_next = stop_first;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            resume_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            resume_reg  <= resume_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && dec_valid) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/scanline_line_follower_steering.sv =====
// Top level of the scan-row line follower with proportional steering.
`timescale 1ns / 1ps

// Takes one gray pixel per cycle on the s_ channel, left to right, with row_end
// on the last pixel of a row, and gives drive decisions on the m_ channel. A
// pixel passes an input register, then the row tracker (threshold compare,
// white count, run length, right edge of the last qualifying run); a row's
// decision goes to the decision register, its result item to the result
// register on m_. A new pixel is taken every cycle while the output side
// keeps up. A stop row gives two items (stop, then resume) from the one
// result register; a row whose edge lies at or beyond steer_limit gives no
// item. Steering speeds come from one 11 x 9 bit multiply in the drive stage.
// The user must write registers through cfg_* only while no item is in
// flight; the block itself does not enforce this. cfg_ready is always high.

module scanline_line_follower_steering
    import slfs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  slfs_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slfs_out_t              m_data
);

    slfs_cfg_t cfg;
    logic      dec_valid;
    slfs_dec_t dec;
    logic      dec_pop;

    slfs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slfs_row_track u_row_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dec_pop   (dec_pop)
    );

    slfs_drive_out u_drive_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dec_pop   (dec_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
